### design/mme_pkg.sv
// Shared types, sizes and helper functions for the matrix multiply engine.
// Used by mme_ctrl, mme_datapath and matrix_multiply_engine_unit.
package mme_pkg;

    // Largest row or column count, and the element width used for storage.
    localparam int MAX_DIM    = 8;
    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Fixed widths of the port fields.
    localparam int VALUE_W   = 32;
    localparam int CMD_W     = 2;
    localparam int POS_W     = 3;
    localparam int REG_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Derived sizes.
    localparam int ELEM_W = (ELEM_WIDTH > VALUE_W) ? VALUE_W : ELEM_WIDTH;
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_A = 2'd0,
        CMD_WRITE_B = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_ROWS = 2'd0,
        CFG_A_COLS = 2'd1,
        CFG_B_ROWS = 2'd2,
        CFG_B_COLS = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ISSUE,
        S_WAIT,
        S_ERROR
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd_en;
        logic             rd_first;
        logic             rd_last;
        logic [IDX_W-1:0] rd_row;
        logic [IDX_W-1:0] rd_col;
        logic [IDX_W-1:0] rd_k;
        logic             emit;
        logic             emit_err;
        logic [IDX_W-1:0] emit_row;
        logic [IDX_W-1:0] emit_col;
        logic             emit_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sum_vld;
        logic out_free;
    } t_dp_stat;

    // A count of zero acts as one, and a count above MAX_DIM acts as MAX_DIM.
    function automatic logic [CNT_W-1:0] eff_count(input logic [REG_W-1:0] v);
        logic [CNT_W-1:0] res;
        if (v == '0) begin
            res = CNT_W'(1);
        end else if (v > REG_W'(MAX_DIM)) begin
            res = CNT_W'(MAX_DIM);
        end else begin
            res = CNT_W'(v);
        end
        return res;
    endfunction

endpackage

### design/mme_ctrl.sv
// Controller of the matrix multiply engine: count registers, command decode
// and the walk over product elements. Depends on mme_pkg.
module mme_ctrl import mme_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CMD_W-1:0]     i_command,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    input  t_dp_stat             i_stat,
    output t_dp_cmd              o_cmd
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_k, n_k;
    logic [REG_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;

    logic [CNT_W-1:0] ar, ac, br, bc;
    logic             last_k, last_row, last_col;

    assign o_cfg_ready = 1'b1;

    assign ar = eff_count(r_a_rows);
    assign ac = eff_count(r_a_cols);
    assign br = eff_count(r_b_rows);
    assign bc = eff_count(r_b_cols);

    assign last_k   = (CNT_W'(r_k) + CNT_W'(1)) == ac;
    assign last_row = (CNT_W'(r_row) + CNT_W'(1)) == ar;
    assign last_col = (CNT_W'(r_col) + CNT_W'(1)) == bc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= REG_W'(1);
            r_a_cols <= REG_W'(1);
            r_b_rows <= REG_W'(1);
            r_b_cols <= REG_W'(1);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_A_ROWS: r_a_rows <= i_cfg_data;
                CFG_A_COLS: r_a_cols <= i_cfg_data;
                CFG_B_ROWS: r_b_rows <= i_cfg_data;
                CFG_B_COLS: r_b_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_k        = r_k;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.rd_row   = r_row;
        o_cmd.rd_col   = r_col;
        o_cmd.rd_k     = r_k;
        o_cmd.emit_row = r_row;
        o_cmd.emit_col = r_col;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (t_cmd'(i_command))
                        CMD_WRITE_A: o_cmd.wr_a = 1'b1;
                        CMD_WRITE_B: o_cmd.wr_b = 1'b1;
                        CMD_COMPUTE: n_state = S_CHECK;
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                if (ac != br) begin
                    n_state = S_ERROR;
                end else begin
                    n_row   = '0;
                    n_col   = '0;
                    n_k     = '0;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_first = (r_k == '0);
                o_cmd.rd_last  = last_k;
                if (last_k) begin
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            S_WAIT: begin
                // The next element starts only after this sum has left the accumulator.
                if (i_stat.sum_vld && i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = last_row && last_col;
                    n_k             = '0;
                    if (last_col) begin
                        n_col = '0;
                        if (last_row) begin
                            n_state = S_IDLE;
                        end else begin
                            n_row   = r_row + IDX_W'(1);
                            n_state = S_ISSUE;
                        end
                    end else begin
                        n_col   = r_col + IDX_W'(1);
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ERROR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/mme_datapath.sv
// Datapath of the matrix multiply engine: the two element memories, the
// multiply-accumulate pipeline, saturation and the output register. Depends on mme_pkg.
module mme_datapath import mme_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [POS_W-1:0]     i_elem_row,
    input  logic [POS_W-1:0]     i_elem_col,
    input  logic [VALUE_W-1:0]   i_elem_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [POS_W-1:0]     o_out_row,
    output logic [POS_W-1:0]     o_out_col,
    output logic [VALUE_W-1:0]   o_out_value,
    output logic                 o_saturated,
    output logic                 o_dim_error,
    output logic                 o_last
);

    localparam logic signed [ACC_W-1:0] MAX_V = (ACC_W'(1) << (ELEM_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] MIN_V = ~MAX_V;

    logic [ELEM_W-1:0] r_mem_a [DEPTH];
    logic [ELEM_W-1:0] r_mem_b [DEPTH];

    logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
    logic              wr_ok;

    logic signed [ELEM_W-1:0] r_a_q, r_b_q;
    logic                     r_s1_vld, r_s1_first, r_s1_last;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_s2_vld, r_s2_first, r_s2_last;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_sum_vld;

    logic signed [ACC_W-1:0]  sum_sh;
    logic                     sat_hi, sat_lo;
    logic signed [ELEM_W-1:0] fin_val;

    logic                     r_out_vld;
    logic [POS_W-1:0]         r_out_row, r_out_col;
    logic [VALUE_W-1:0]       r_out_value;
    logic                     r_out_sat, r_out_err, r_out_last;
    logic                     out_free;

    assign wr_ok = (32'(i_elem_row) < 32'(MAX_DIM)) && (32'(i_elem_col) < 32'(MAX_DIM));
    assign wr_addr = ADDR_W'(i_elem_row) * ADDR_W'(MAX_DIM) + ADDR_W'(i_elem_col);
    assign rd_addr_a = ADDR_W'(i_cmd.rd_row) * ADDR_W'(MAX_DIM) + ADDR_W'(i_cmd.rd_k);
    assign rd_addr_b = ADDR_W'(i_cmd.rd_k) * ADDR_W'(MAX_DIM) + ADDR_W'(i_cmd.rd_col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a && wr_ok) begin
            r_mem_a[wr_addr] <= i_elem_value[ELEM_W-1:0];
        end
        if (i_cmd.rd_en) begin
            r_a_q <= r_mem_a[rd_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b && wr_ok) begin
            r_mem_b[wr_addr] <= i_elem_value[ELEM_W-1:0];
        end
        if (i_cmd.rd_en) begin
            r_b_q <= r_mem_b[rd_addr_b];
        end
    end

    // Pipeline control: read, multiply, accumulate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_sum_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.rd_en;
            r_s2_vld <= r_s1_vld;
            if (i_cmd.emit) begin
                r_sum_vld <= 1'b0;
            end else if (r_s2_vld && r_s2_last) begin
                r_sum_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.rd_first;
        r_s1_last  <= i_cmd.rd_last;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_prod     <= r_a_q * r_b_q;
        if (r_s2_vld) begin
            r_acc <= r_s2_first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
    end

    // The sum drops its fraction bits (rounding toward minus infinity) and clips.
    always_comb begin
        sum_sh = r_acc >>> FRAC_BITS;
        sat_hi = sum_sh > MAX_V;
        sat_lo = sum_sh < MIN_V;
        if (sat_hi) begin
            fin_val = MAX_V[ELEM_W-1:0];
        end else if (sat_lo) begin
            fin_val = MIN_V[ELEM_W-1:0];
        end else begin
            fin_val = sum_sh[ELEM_W-1:0];
        end
    end

    assign out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_err) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_row   <= POS_W'(i_cmd.emit_row);
            r_out_col   <= POS_W'(i_cmd.emit_col);
            r_out_value <= VALUE_W'(fin_val);
            r_out_sat   <= sat_hi || sat_lo;
            r_out_err   <= 1'b0;
            r_out_last  <= i_cmd.emit_last;
        end else if (i_cmd.emit_err) begin
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_out_value <= '0;
            r_out_sat   <= 1'b0;
            r_out_err   <= 1'b1;
            r_out_last  <= 1'b1;
        end
    end

    assign o_stat.sum_vld  = r_sum_vld;
    assign o_stat.out_free = out_free;

    assign o_out_valid = r_out_vld;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_saturated = r_out_sat;
    assign o_dim_error = r_out_err;
    assign o_last      = r_out_last;

    // A word is never loaded over one that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.emit_err) |-> out_free)
        else $error("output word overwritten before it was taken");

    // A product element is sent only once its sum is complete.
    a_emit_needs_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_sum_vld)
        else $error("product element sent before its sum was complete");

    // A finished sum is never replaced by the next one before it is sent.
    a_sum_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2_last) |-> !r_sum_vld)
        else $error("finished sum overwritten before it was sent");

    // Memory reads and element writes never share a cycle.
    a_rd_wr_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> !(i_cmd.wr_a || i_cmd.wr_b))
        else $error("element write during a product walk");

endmodule

### design/matrix_multiply_engine_unit.sv
// Top level of the matrix multiply engine: joins the controller and the datapath.
// Depends on mme_pkg, mme_ctrl and mme_datapath.
//
// Usage:
// - Input channel (i_in_valid / o_in_ready) carries one command word. Writes
//   of A or B elements stream at one word per cycle.
// - A compute word checks A's column count against B's row count in the cycle
//   after it is taken. On a mismatch one error word (dim_error and last set)
//   is loaded into the output register in the next cycle the register is free.
// - Otherwise every element of A times B comes out in row-major order, the
//   final one with last set. Each element reads one A/B pair per cycle from
//   the element memories, and the columns of A are walked through the read,
//   multiply and accumulate stages.
// - Input is not taken while a product walk runs; it is taken again once the
//   final element is in the output register.
// - Configuration port (i_cfg_valid / o_cfg_ready) writes the four count
//   registers and is always ready; write it only while the engine is idle.
// - Reset sets all counts to one; the element memories hold nothing defined
//   until written. If the receiver stalls, the output register holds its word,
//   the next element's sum is formed and then held until the register is free.
module matrix_multiply_engine_unit import mme_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [POS_W-1:0]     i_elem_row,
    input  logic [POS_W-1:0]     i_elem_col,
    input  logic [VALUE_W-1:0]   i_elem_value,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [POS_W-1:0]     o_out_row,
    output logic [POS_W-1:0]     o_out_col,
    output logic [VALUE_W-1:0]   o_out_value,
    output logic                 o_saturated,
    output logic                 o_dim_error,
    output logic                 o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    mme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    mme_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_elem_row   (i_elem_row),
        .i_elem_col   (i_elem_col),
        .i_elem_value (i_elem_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_out_value  (o_out_value),
        .o_saturated  (o_saturated),
        .o_dim_error  (o_dim_error),
        .o_last       (o_last)
    );

endmodule
